### hdl/chcp_pkg.sv
// ----------------------------------------------------------------------------
// chcp_pkg: shared constants for the cubic curve point sampler
// Default field widths and the stage counts of the axis lanes and the
// whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package chcp_pkg;

  localparam int T_FRAC_BITS_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  // Register stages inside one axis lane.
  localparam int LANE_STAGES = 8;
  // Lane stages plus the merging output stage.
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  localparam logic KIND_HERMITE = 1'b0;
  localparam logic KIND_BEZIER  = 1'b1;

endpackage

`default_nettype wire

### hdl/chcp_lane.sv
// ----------------------------------------------------------------------------
// chcp_lane: one axis of the cubic curve evaluator
// Builds the Hermite coefficients, runs three Horner steps, the last two with
// split partial products, then rounds half away from zero and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module chcp_lane #(
  parameter int T_FRAC_BITS = chcp_pkg::T_FRAC_BITS_DEF,
  parameter int COORD_BITS  = chcp_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic [chcp_pkg::LANE_STAGES-1:0]   en,
  input  wire logic                               curve_kind,
  input  wire logic signed [COORD_BITS-1:0]       pt0,
  input  wire logic signed [COORD_BITS-1:0]       pt1,
  input  wire logic signed [COORD_BITS-1:0]       pt2,
  input  wire logic signed [COORD_BITS-1:0]       pt3,
  input  wire logic [T_FRAC_BITS:0]               t_param,
  output logic signed [COORD_BITS-1:0]            point,
  output logic                                    clipped
);

  localparam int C  = COORD_BITS;
  localparam int F  = T_FRAC_BITS;
  localparam int KW = C + 6;
  localparam int TW = F + 1;
  localparam int W1 = KW + TW + 2;
  localparam int W2 = W1 + TW + 1;
  localparam int W3 = W2 + TW + 1;
  localparam int L1 = W1 / 2;
  localparam int H1 = W1 - L1;
  localparam int L2 = W2 / 2;
  localparam int H2 = W2 - L2;
  localparam int SH = 3 * F;
  localparam int QW = W3 + 1 - SH;

  // Stage 0: coefficients.
  logic signed [KW-1:0] k0_s0, k1_s0, k2_s0, k3_s0;
  logic [TW-1:0]        t_s0;
  // Stage 1: first Horner step.
  logic signed [W1-1:0] acc1_s1;
  logic signed [KW-1:0] k2_s1, k3_s1;
  logic [TW-1:0]        t_s1;
  // Stage 2: partial products of the second step.
  logic [L1+TW-1:0]     pl_s2;
  logic signed [H1+TW:0] ph_s2;
  logic signed [KW-1:0] k2_s2, k3_s2;
  logic [TW-1:0]        t_s2;
  // Stage 3: second Horner step.
  logic signed [W2-1:0] acc2_s3;
  logic signed [KW-1:0] k3_s3;
  logic [TW-1:0]        t_s3;
  // Stage 4: partial products of the third step.
  logic [L2+TW-1:0]     pl_s4;
  logic signed [H2+TW:0] ph_s4;
  logic signed [KW-1:0] k3_s4;
  // Stage 5: third Horner step.
  logic signed [W3-1:0] acc3_s5;
  // Stage 6: sign and magnitude.
  logic                 neg_s6;
  logic [W3-1:0]        mag_s6;

  logic signed [KW-1:0] k0_c, k1_c, k2_c, k3_c;

  always_comb begin
    logic signed [KW-1:0] p, b, c, q, s0, s1, d0, d1;
    p  = KW'(pt0);
    b  = KW'(pt1);
    c  = KW'(pt2);
    q  = KW'(pt3);
    d0 = b - p;
    d1 = q - c;
    if (curve_kind == chcp_pkg::KIND_BEZIER) begin
      s0 = (d0 <<< 1) + d0;
      s1 = (d1 <<< 1) + d1;
    end else begin
      s0 = b;
      s1 = c;
    end
    k0_c = (p <<< 1) + s0 - (q <<< 1) + s1;
    k1_c = (q <<< 1) + q - (p <<< 1) - p - (s0 <<< 1) - s1;
    k2_c = s0;
    k3_c = p;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k0_s0 <= k0_c;
      k1_s0 <= k1_c;
      k2_s0 <= k2_c;
      k3_s0 <= k3_c;
      t_s0  <= t_param;
    end
  end

  logic signed [KW+TW:0] prod1;
  logic signed [TW:0]    ts0;
  assign ts0   = $signed({1'b0, t_s0});
  assign prod1 = k0_s0 * ts0;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      acc1_s1 <= W1'(prod1) + (W1'(k1_s0) <<< F);
      k2_s1   <= k2_s0;
      k3_s1   <= k3_s0;
      t_s1    <= t_s0;
    end
  end

  logic [L1-1:0]        lo1;
  logic signed [H1-1:0] hi1;
  logic signed [TW:0]   ts1;
  assign lo1 = acc1_s1[L1-1:0];
  assign hi1 = $signed(acc1_s1[W1-1:L1]);
  assign ts1 = $signed({1'b0, t_s1});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pl_s2 <= lo1 * t_s1;
      ph_s2 <= hi1 * ts1;
      k2_s2 <= k2_s1;
      k3_s2 <= k3_s1;
      t_s2  <= t_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      acc2_s3 <= (W2'(ph_s2) <<< L1) + W2'($signed({1'b0, pl_s2}))
                 + (W2'(k2_s2) <<< (2 * F));
      k3_s3   <= k3_s2;
      t_s3    <= t_s2;
    end
  end

  logic [L2-1:0]        lo2;
  logic signed [H2-1:0] hi2;
  logic signed [TW:0]   ts3;
  assign lo2 = acc2_s3[L2-1:0];
  assign hi2 = $signed(acc2_s3[W2-1:L2]);
  assign ts3 = $signed({1'b0, t_s3});

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pl_s4 <= lo2 * t_s3;
      ph_s4 <= hi2 * ts3;
      k3_s4 <= k3_s3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      acc3_s5 <= (W3'(ph_s4) <<< L2) + W3'($signed({1'b0, pl_s4}))
                 + (W3'(k3_s4) <<< SH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      neg_s6 <= acc3_s5[W3-1];
      mag_s6 <= acc3_s5[W3-1] ? (~acc3_s5 + W3'(1)) : acc3_s5;
    end
  end

  logic [C-1:0] value_c;
  logic         over_c;

  always_comb begin
    logic [W3:0]  sum;
    logic [QW-1:0] qv;
    logic [C-1:0] limit;
    logic [C-1:0] mg;
    sum    = {1'b0, mag_s6} + ((W3 + 1)'(1) << (SH - 1));
    qv     = sum[W3:SH];
    limit  = neg_s6 ? {1'b1, {(C - 1){1'b0}}} : {1'b0, {(C - 1){1'b1}}};
    over_c = qv > QW'(limit);
    mg     = over_c ? limit : qv[C-1:0];
    value_c = neg_s6 ? (~mg + C'(1)) : mg;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      point   <= $signed(value_c);
      clipped <= over_c;
    end
  end

endmodule

`default_nettype wire

### hdl/chcp_merge.sv
// ----------------------------------------------------------------------------
// chcp_merge: output stage of the cubic curve point sampler
// Joins the x and y lanes, combines their saturation flags and packs the
// result item into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chcp_merge #(
  parameter int COORD_BITS = chcp_pkg::COORD_BITS_DEF,
  parameter int OUT_W      = 32
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic                         clip_x,
  input  wire logic                         clip_y,
  input  wire logic                         starts_path,
  output logic [OUT_W-1:0]                  tdata,
  output logic [1:0]                        tuser
);

  always_ff @(posedge clk) begin
    if (en) begin
      tdata <= OUT_W'({point_y, point_x});
      tuser <= {clip_x | clip_y, starts_path};
    end
  end

endmodule

`default_nettype wire

### hdl/cubic_hermite_curve_point.sv
// Each accepted input item passes through the lane stages and then the merging stage.
// Throughput: one item per clock while the output is not stalled; each stage
// moves on when the next one is empty or moving, so a stalled output only backs up full stages.
// Reset clears the stage valid bits only; data registers keep no reset.
// ----------------------------------------------------------------------------
// cubic_hermite_curve_point: Hermite or Bezier curve point sampler
// Two axis lanes evaluate the cubic at t in parallel; a merging stage
// packs the rounded, saturated point with its path-start and clip flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_hermite_curve_point #(
  parameter int T_FRAC_BITS = chcp_pkg::T_FRAC_BITS_DEF,
  parameter int COORD_BITS  = chcp_pkg::COORD_BITS_DEF,
  localparam int IN_BITS    = 8 * COORD_BITS + T_FRAC_BITS + 1,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, t_param, zero pad
  input  wire logic [IN_W-1:0]  s_tdata,
  // curve_kind
  input  wire logic [0:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // point_x, point_y, zero pad
  output logic [OUT_W-1:0]      m_tdata,
  // starts_path, clipped
  output logic [1:0]            m_tuser
);

  localparam int NST = chcp_pkg::PIPE_STAGES;
  localparam int NL  = chcp_pkg::LANE_STAGES;
  localparam int C   = COORD_BITS;
  localparam int TW  = T_FRAC_BITS + 1;

  logic [NST-1:0] vld, vld_next, vin, en;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
    vin = {vld[NST-2:0], s_tvalid};
    en  = vin & rdy[NST-1:0];
    for (int i = 0; i < NST; i++) begin
      vld_next[i] = rdy[i] ? vin[i] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NST-1];

  logic [TW-1:0] t_in;
  assign t_in = s_tdata[8*C +: TW];

  logic [NL-1:0] sp;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sp[0] <= (t_in == '0);
    end
    for (int i = 1; i < NL; i++) begin
      if (en[i]) begin
        sp[i] <= sp[i - 1];
      end
    end
  end

  logic signed [C-1:0] px, py;
  logic                cx, cy;

  chcp_lane #(.T_FRAC_BITS(T_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_lane_x (
    .clk        (clk),
    .en         (en[NL-1:0]),
    .curve_kind (s_tuser[0]),
    .pt0        ($signed(s_tdata[0*C +: C])),
    .pt1        ($signed(s_tdata[2*C +: C])),
    .pt2        ($signed(s_tdata[4*C +: C])),
    .pt3        ($signed(s_tdata[6*C +: C])),
    .t_param    (t_in),
    .point      (px),
    .clipped    (cx)
  );

  chcp_lane #(.T_FRAC_BITS(T_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_lane_y (
    .clk        (clk),
    .en         (en[NL-1:0]),
    .curve_kind (s_tuser[0]),
    .pt0        ($signed(s_tdata[1*C +: C])),
    .pt1        ($signed(s_tdata[3*C +: C])),
    .pt2        ($signed(s_tdata[5*C +: C])),
    .pt3        ($signed(s_tdata[7*C +: C])),
    .t_param    (t_in),
    .point      (py),
    .clipped    (cy)
  );

  chcp_merge #(.COORD_BITS(COORD_BITS), .OUT_W(OUT_W)) u_merge (
    .clk         (clk),
    .en          (en[NST-1]),
    .point_x     (px),
    .point_y     (py),
    .clip_x      (cx),
    .clip_y      (cy),
    .starts_path (sp[NL-1]),
    .tdata       (m_tdata),
    .tuser       (m_tuser)
  );

`ifndef SYNTH
  // At t equal to zero the point is the start point itself, never clipped.
  a_start_not_clipped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("path start point reported as clipped");

  // With the output stage empty every stage can move, so input is taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NST-1] |-> s_tready)
    else $error("input stalled while output stage is empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item present right after reset");
`endif

endmodule

`default_nettype wire
